[hdl/smft_pkg.sv]
// ----------------------------------------------------------------------------
// smft_pkg
// Shared types and constants of the sparse matrix fast transpose core.
// ----------------------------------------------------------------------------
package smft_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 16;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int REG_W   = 6;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_LSB = 2;

  localparam int TIDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int CADDR_W    = $clog2(MAX_DIM);
  localparam int LOC_W      = TIDX_W + 1;
  localparam int TRAM_DEPTH = 2 ** LOC_W;

  localparam logic [REG_W-1:0] RESET_DIM = REG_W'(32);

  typedef struct packed {
    logic [ROW_W-1:0]             row;
    logic [COL_W-1:0]             col;
    logic signed [VALUE_BITS-1:0] value;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  typedef struct packed {
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] cols;
  } cfg_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CLR     = 12'b0000_0000_0010,
    S_CNT_RD  = 12'b0000_0000_0100,
    S_CNT_COL = 12'b0000_0000_1000,
    S_CNT_WR  = 12'b0000_0001_0000,
    S_PF_RD   = 12'b0000_0010_0000,
    S_PF_WR   = 12'b0000_0100_0000,
    S_PL_RD   = 12'b0000_1000_0000,
    S_PL_COL  = 12'b0001_0000_0000,
    S_PL_WR   = 12'b0010_0000_0000,
    S_HDR     = 12'b0100_0000_0000,
    S_EMIT    = 12'b1000_0000_0000
  } state_e;

endpackage

[hdl/smft_ram.sv]
// ----------------------------------------------------------------------------
// smft_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/smft_cfg.sv]
// ----------------------------------------------------------------------------
// smft_cfg
// APB register file for the matrix dimensions, with clamped effective values.
// ----------------------------------------------------------------------------
module smft_cfg import smft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [REG_W-1:0] rows_q, rows_d;
  logic [REG_W-1:0] cols_q, cols_d;
  logic             wr_en;
  reg_e             reg_sel;

  function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > REG_W'(MAX_DIM)) begin
      r = REG_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[REG_LSB]);
  assign pready  = 1'b1;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ROWS: rows_d = pwdata[REG_W-1:0];
        REG_COLS: cols_d = pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RESET_DIM;
      cols_q <= RESET_DIM;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS: prdata = APB_DW'(rows_q);
      REG_COLS: prdata = APB_DW'(cols_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.rows = clamp_dim(rows_q);
  assign cfg_o.cols = clamp_dim(cols_q);

endmodule

[hdl/sparse_matrix_fast_transpose_core.sv]
// ----------------------------------------------------------------------------
// sparse_matrix_fast_transpose_core
// Sparse matrix transpose in coordinate form by column counts and prefix sums.
//
// Input transactions are taken at a clock edge with start high and busy low.
// A load (op 0) stores one (row, column, value) term and yields no result;
// loads can follow back to back. A term past capacity or with a column
// outside the matrix is dropped and flags overflow in the header.
// A finish (op 1) raises busy and runs a sequencer over two RAMs: a term RAM
// (stored terms and the placed, transposed terms) and a column RAM (counts,
// then start positions). It first clears the used columns of the column RAM,
// then counts the stored terms per column, turns the counts into start
// positions by prefix sums and places each term at its position in the
// upper half; a term whose column is now outside the matrix is skipped in
// both passes and flags overflow. Then it emits one header and one term
// per cycle; an empty store goes straight from the clear to the header.
// Each result is shown for one cycle with result_valid_o; the receiver
// cannot stall, so the run never pauses. last_o marks the final result.
// Reset empties the term store and sets both dimensions to 32; the column
// RAM needs no clearing pass since each finish clears the used columns.
// ----------------------------------------------------------------------------
module sparse_matrix_fast_transpose_core import smft_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [ROW_W-1:0]             term_row_i,
  input  logic [COL_W-1:0]             term_col_i,
  input  logic signed [VALUE_BITS-1:0] term_value_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  output logic                         result_valid_o,
  output logic                         is_header_o,
  output logic [REG_W-1:0]             out_row_o,
  output logic [REG_W-1:0]             out_col_o,
  output logic signed [VALUE_BITS-1:0] out_value_o,
  output logic                         overflow_o,
  output logic                         last_o
);

  cfg_t cfg;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] tcount_q, tcount_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [CNT_W-1:0] sum_q, sum_d;
  logic [REG_W-1:0] col_q, col_d;
  logic             dropped_q, dropped_d;
  logic             ovf_q, ovf_d;

  logic                         res_valid_q, res_valid_d;
  logic                         res_hdr_q, res_hdr_d;
  logic [REG_W-1:0]             res_row_q, res_row_d;
  logic [REG_W-1:0]             res_col_q, res_col_d;
  logic signed [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic                         res_ovf_q, res_ovf_d;
  logic                         res_last_q, res_last_d;

  logic               t_we, t_re;
  logic [LOC_W-1:0]   t_waddr, t_raddr;
  term_t              t_wdata;
  logic [TERM_W-1:0]  t_rdata;
  term_t              t_rd;
  logic               c_we, c_re;
  logic [CADDR_W-1:0] c_waddr, c_raddr;
  logic [CNT_W-1:0]   c_wdata, c_rdata;

  logic               load_ok;
  logic               rd_col_ok;
  logic [CADDR_W-1:0] rd_col_addr;
  logic               last_term;
  logic               last_col;
  term_t              in_term;

  smft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // lower half holds loaded terms, upper half the transposed order
  smft_ram #(
    .WIDTH (TERM_W),
    .DEPTH (TRAM_DEPTH)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // column counts, rewritten in place as start positions
  smft_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_DIM)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign t_rd          = term_t'(t_rdata);
  assign in_term.row   = term_row_i;
  assign in_term.col   = term_col_i;
  assign in_term.value = term_value_i;

  assign load_ok     = (tcount_q < CNT_W'(MAX_TERMS)) && (REG_W'(term_col_i) < cfg.cols);
  assign rd_col_ok   = REG_W'(t_rd.col) < cfg.cols;
  assign rd_col_addr = CADDR_W'(t_rd.col);
  assign last_term   = (idx_q + CNT_W'(1)) == tcount_q;
  assign last_col    = (col_q + REG_W'(1)) == cfg.cols;

  always_comb begin
    state_d     = state_q;
    tcount_d    = tcount_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    sum_d       = sum_q;
    col_d       = col_q;
    dropped_d   = dropped_q;
    ovf_d       = ovf_q;
    res_valid_d = 1'b0;
    res_hdr_d   = res_hdr_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    res_val_d   = res_val_q;
    res_ovf_d   = res_ovf_q;
    res_last_d  = res_last_q;
    t_we        = 1'b0;
    t_waddr     = '0;
    t_wdata     = in_term;
    t_re        = 1'b0;
    t_raddr     = '0;
    c_we        = 1'b0;
    c_waddr     = '0;
    c_wdata     = '0;
    c_re        = 1'b0;
    c_raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (start && op_e'(op_i) == OP_LOAD) begin
          if (load_ok) begin
            t_we     = 1'b1;
            t_waddr  = {1'b0, tcount_q[TIDX_W-1:0]};
            tcount_d = tcount_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
        end else if (start && op_e'(op_i) == OP_FINISH) begin
          state_d = S_CLR;
          col_d   = '0;
          idx_d   = '0;
          kept_d  = '0;
          ovf_d   = dropped_q;
        end
      end
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = col_q[CADDR_W-1:0];
        col_d   = col_q + REG_W'(1);
        if (last_col) begin
          state_d = (tcount_q == '0) ? S_HDR : S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        t_re    = 1'b1;
        t_raddr = {1'b0, idx_q[TIDX_W-1:0]};
        state_d = S_CNT_COL;
      end
      S_CNT_COL: begin
        if (rd_col_ok) begin
          c_re    = 1'b1;
          c_raddr = rd_col_addr;
          state_d = S_CNT_WR;
        end else begin
          ovf_d = 1'b1;
          idx_d = idx_q + CNT_W'(1);
          if (last_term) begin
            state_d = S_PF_RD;
            col_d   = '0;
            sum_d   = '0;
          end else begin
            state_d = S_CNT_RD;
          end
        end
      end
      S_CNT_WR: begin
        c_we    = 1'b1;
        c_waddr = rd_col_addr;
        c_wdata = c_rdata + CNT_W'(1);
        kept_d  = kept_q + CNT_W'(1);
        idx_d   = idx_q + CNT_W'(1);
        if (last_term) begin
          state_d = S_PF_RD;
          col_d   = '0;
          sum_d   = '0;
        end else begin
          state_d = S_CNT_RD;
        end
      end
      S_PF_RD: begin
        c_re    = 1'b1;
        c_raddr = col_q[CADDR_W-1:0];
        state_d = S_PF_WR;
      end
      S_PF_WR: begin
        c_we    = 1'b1;
        c_waddr = col_q[CADDR_W-1:0];
        c_wdata = sum_q;
        sum_d   = sum_q + c_rdata;
        col_d   = col_q + REG_W'(1);
        if (last_col) begin
          state_d = S_PL_RD;
          idx_d   = '0;
        end else begin
          state_d = S_PF_RD;
        end
      end
      S_PL_RD: begin
        t_re    = 1'b1;
        t_raddr = {1'b0, idx_q[TIDX_W-1:0]};
        state_d = S_PL_COL;
      end
      S_PL_COL: begin
        if (rd_col_ok) begin
          c_re    = 1'b1;
          c_raddr = rd_col_addr;
          state_d = S_PL_WR;
        end else begin
          idx_d = idx_q + CNT_W'(1);
          if (last_term) begin
            state_d = S_HDR;
            idx_d   = '0;
          end else begin
            state_d = S_PL_RD;
          end
        end
      end
      S_PL_WR: begin
        t_we    = 1'b1;
        t_waddr = {1'b1, c_rdata[TIDX_W-1:0]};
        t_wdata = t_rd;
        c_we    = 1'b1;
        c_waddr = rd_col_addr;
        c_wdata = c_rdata + CNT_W'(1);
        idx_d   = idx_q + CNT_W'(1);
        if (last_term) begin
          state_d = S_HDR;
          idx_d   = '0;
        end else begin
          state_d = S_PL_RD;
        end
      end
      S_HDR: begin
        res_valid_d = 1'b1;
        res_hdr_d   = 1'b1;
        res_row_d   = cfg.cols;
        res_col_d   = cfg.rows;
        res_val_d   = VALUE_BITS'(kept_q);
        res_ovf_d   = ovf_q;
        res_last_d  = (kept_q == '0);
        tcount_d    = '0;
        dropped_d   = 1'b0;
        if (kept_q == '0) begin
          state_d = S_IDLE;
        end else begin
          t_re    = 1'b1;
          t_raddr = {1'b1, idx_q[TIDX_W-1:0]};
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid_d = 1'b1;
        res_hdr_d   = 1'b0;
        res_row_d   = REG_W'(t_rd.col);
        res_col_d   = REG_W'(t_rd.row);
        res_val_d   = t_rd.value;
        res_ovf_d   = 1'b0;
        res_last_d  = (idx_q == kept_q);
        if (idx_q == kept_q) begin
          state_d = S_IDLE;
        end else begin
          t_re    = 1'b1;
          t_raddr = {1'b1, idx_q[TIDX_W-1:0]};
          idx_d   = idx_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tcount_q    <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      sum_q       <= '0;
      col_q       <= '0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tcount_q    <= tcount_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      sum_q       <= sum_d;
      col_q       <= col_d;
      dropped_q   <= dropped_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hdr_q  <= res_hdr_d;
    res_row_q  <= res_row_d;
    res_col_q  <= res_col_d;
    res_val_q  <= res_val_d;
    res_ovf_q  <= res_ovf_d;
    res_last_q <= res_last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign is_header_o    = res_hdr_q;
  assign out_row_o      = res_row_q;
  assign out_col_o      = res_col_q;
  assign out_value_o    = res_val_q;
  assign overflow_o     = res_ovf_q;
  assign last_o         = res_last_q;

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("transaction run ended without last");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= CNT_W'(MAX_TERMS))
    else $error("term count past capacity");

  a_header_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_header_o |-> $past(state_q == S_HDR))
    else $error("header outside header step");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> idx_q <= kept_q)
    else $error("emit index past kept terms");

endmodule
